// File: sv/tcse_pkg.sv
package tcse_pkg;

  // Sizing of the debounce table and of the sample index.
  localparam int RECENT_DEPTH = 32;
  localparam int INDEX_BITS   = 32;
  localparam int FRAC_BITS    = 8;

  // Fixed field widths of the channels and the register file.
  localparam int SAMPLE_W   = 40;
  localparam int CODE_W     = 32;
  localparam int FIELD_W    = 32;
  localparam int THR_W      = 16;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam int IDX_W   = (RECENT_DEPTH > 1) ? $clog2(RECENT_DEPTH) : 1;
  localparam int FILL_W  = $clog2(RECENT_DEPTH + 1);
  localparam int CMP_W   = (INDEX_BITS > 32) ? INDEX_BITS : 32;
  localparam int ENTRY_W = CODE_W + INDEX_BITS;

  // Rounding offset: one half in the sample's fixed-point format.
  localparam logic [SAMPLE_W+1:0] ROUND_HALF = (SAMPLE_W + 2)'((1 << FRAC_BITS) >> 1);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_CODE_MASK    = 2'd0,
    REG_ZERO_THR     = 2'd1,
    REG_DROP_ZERO    = 2'd2,
    REG_MIN_INTERVAL = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_value;
    logic                       sample_invalid;
    logic                       record_end;
  } in_item_t;

  typedef struct packed {
    logic signed [CODE_W-1:0] event_code;
    logic [FIELD_W-1:0]       onset_index;
    logic [FIELD_W-1:0]       duration_samples;
    logic                     final_event;
  } out_item_t;

  typedef struct packed {
    logic [CODE_W-1:0]  code_mask;
    logic [THR_W-1:0]   zero_threshold;
    logic               drop_zero_codes;
    logic [FIELD_W-1:0] min_interval_samples;
  } cfg_regs_t;

  typedef struct packed {
    logic [CODE_W-1:0]     code;
    logic [INDEX_BITS-1:0] onset;
  } recent_entry_t;

endpackage

// File: sv/tcse_ram.sv
module tcse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// File: sv/tcse_decode.sv
module tcse_decode import tcse_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  in_item_t          sample,
  input  cfg_regs_t         cfg,
  output logic              done,
  output logic [CODE_W-1:0] code
);

  logic              v1_r, v2_r, v3_r;
  logic [CODE_W-1:0] rmag_r;
  logic              neg1_r;
  logic              inv1_r, inv2_r;
  logic [CODE_W-1:0] code2_r;
  logic [CODE_W-1:0] cur_r;

  logic [SAMPLE_W+1:0] sv;
  logic [SAMPLE_W+1:0] rnd;
  logic                neg;
  logic [CODE_W-1:0]   signed_code;
  logic [CODE_W-1:0]   mask_eff;
  logic [CODE_W-1:0]   cmag;
  logic                small_mag;

  // Stage 1: magnitude plus one half in a single subtract or add.
  always_comb begin
    sv  = (SAMPLE_W + 2)'(sample.sample_value);
    neg = sample.sample_value[SAMPLE_W-1];
    rnd = neg ? (ROUND_HALF - sv) : (sv + ROUND_HALF);
  end

  // Stage 2: restore sign modulo 2^32 and mask.
  always_comb begin
    signed_code = neg1_r ? (CODE_W'(0) - rmag_r) : rmag_r;
    mask_eff    = (cfg.code_mask == '0) ? '1 : cfg.code_mask;
  end

  // Stage 3: magnitude of the 32-bit code against the threshold.
  always_comb begin
    cmag      = code2_r[CODE_W-1] ? (CODE_W'(0) - code2_r) : code2_r;
    small_mag = cmag <= CODE_W'(cfg.zero_threshold);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rmag_r <= CODE_W'(rnd >> FRAC_BITS);
      neg1_r <= neg;
      inv1_r <= sample.sample_invalid;
    end
    if (v1_r) begin
      code2_r <= signed_code & mask_eff;
      inv2_r  <= inv1_r;
    end
    if (v2_r) begin
      cur_r <= (inv2_r || small_mag) ? '0 : code2_r;
    end
  end

  assign done = v3_r;
  assign code = cur_r;

endmodule

// File: sv/tcse_match.sv
module tcse_match import tcse_pkg::*; (
  input  recent_entry_t         entry,
  input  logic [CODE_W-1:0]     code,
  input  logic [INDEX_BITS-1:0] t,
  input  logic [FIELD_W-1:0]    min_interval,
  output logic                  hit
);

  logic [INDEX_BITS-1:0] diff;

  // One subtract and three compares: the entry blocks the code if it holds
  // that code, began no later than t and less than the window before it.
  always_comb begin
    diff = t - entry.onset;
    hit  = (entry.code == code) && (t >= entry.onset) &&
           (CMP_W'(diff) < CMP_W'(min_interval));
  end

endmodule

// File: sv/trigger_code_segment_extractor_unit.sv
// Trigger code segment extractor.
// Input channel (in_valid / in_stall / in_data): one trigger sample per
// transfer, signed fixed point with FRAC_BITS fraction bits, a non-finite
// flag and an end-of-recording flag. Output channel (out_valid / out_stall /
// out_data): one event per transfer with code, onset index, duration and a
// final-run flag. Config port (cfg_we / cfg_addr / cfg_wdata): write while idle.
// One sample is worked on at a time; in_stall is low only between samples.
// A sample that closes no run passes the three decode stages and the run
// update before in_stall drops again. Each closed run is then checked and,
// if kept, emitted, after a scan of the filled entries of the debounce table
// when debounce is on, since a single compare unit walks the table RAM one
// entry per cycle. Events sit in one output register, so a new sample is
// taken while an event waits; if the receiver stalls and a second event is
// ready, the sequencer holds until the register frees. Reset clears the run
// tracker, the table fill count and the control and config registers
// (drop_zero_codes resets to 1); the table RAM needs no clearing pass
// because only entries below the fill count are read.
module trigger_code_segment_extractor_unit import tcse_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_UPDATE = 7'b0000100,
    S_CHECK  = 7'b0001000,
    S_SCAN   = 7'b0010000,
    S_EMIT   = 7'b0100000,
    S_NEXT   = 7'b1000000
  } state_t;

  state_t                state_r, state_nxt;
  cfg_regs_t             cfg_r;
  logic                  rec_end_r, rec_end_nxt;
  logic [CODE_W-1:0]     prev_code_r, prev_code_nxt;
  logic [INDEX_BITS-1:0] run_start_r, run_start_nxt;
  logic [INDEX_BITS-1:0] sample_count_r, sample_count_nxt;
  logic                  started_r, started_nxt;
  logic [FILL_W-1:0]     recent_fill_r, recent_fill_nxt;
  logic [IDX_W-1:0]      replace_slot_r, replace_slot_nxt;
  logic [CODE_W-1:0]     cl_code_r, cl_code_nxt;
  logic [INDEX_BITS-1:0] cl_start_r, cl_start_nxt;
  logic [INDEX_BITS-1:0] cl_end_r, cl_end_nxt;
  logic                  cl_final_r, cl_final_nxt;
  logic                  end_pend_r, end_pend_nxt;
  logic [IDX_W-1:0]      scan_idx_r, scan_idx_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  logic                  in_xfer;
  logic                  dec_done;
  logic [CODE_W-1:0]     dec_code;
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [IDX_W-1:0]      ram_raddr;
  logic [ENTRY_W-1:0]    ram_rdata;
  recent_entry_t         wr_entry;
  recent_entry_t         rd_entry;
  logic                  scan_hit;

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Three-stage decoder: round, sign and mask, threshold.
  tcse_decode u_decode (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_xfer),
    .sample(in_data),
    .cfg   (cfg_r),
    .done  (dec_done),
    .code  (dec_code)
  );

  // Debounce table: code and onset of recently emitted events.
  assign wr_entry = '{code: cl_code_r, onset: cl_start_r};
  assign rd_entry = recent_entry_t'(ram_rdata);

  tcse_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(RECENT_DEPTH)
  ) u_recent (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ENTRY_W'(wr_entry)),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Shared compare unit, stepped over the table one entry a cycle.
  tcse_match u_match (
    .entry       (rd_entry),
    .code        (cl_code_r),
    .t           (cl_start_r),
    .min_interval(cfg_r.min_interval_samples),
    .hit         (scan_hit)
  );

  // Write address: append while the table fills, then replace oldest first.
  assign ram_waddr = (recent_fill_r < FILL_W'(RECENT_DEPTH)) ? IDX_W'(recent_fill_r)
                                                             : replace_slot_r;
  // Read entry 0 on the way into the scan, then always one ahead.
  assign ram_raddr = (state_r == S_CHECK) ? '0 : IDX_W'(scan_idx_r + 1'b1);

  always_comb begin
    logic                  changed;
    logic [INDEX_BITS-1:0] count_inc;

    state_nxt        = state_r;
    rec_end_nxt      = rec_end_r;
    prev_code_nxt    = prev_code_r;
    run_start_nxt    = run_start_r;
    sample_count_nxt = sample_count_r;
    started_nxt      = started_r;
    recent_fill_nxt  = recent_fill_r;
    replace_slot_nxt = replace_slot_r;
    cl_code_nxt      = cl_code_r;
    cl_start_nxt     = cl_start_r;
    cl_end_nxt       = cl_end_r;
    cl_final_nxt     = cl_final_r;
    end_pend_nxt     = end_pend_r;
    scan_idx_nxt     = scan_idx_r;
    out_valid_nxt    = out_valid_r;
    out_data_nxt     = out_data_r;
    ram_we           = 1'b0;
    changed          = 1'b0;
    // Saturate the sample index at its all-ones value.
    count_inc = (sample_count_r == '1) ? sample_count_r : sample_count_r + 1'b1;

    // Drop the waiting event once the receiver takes it.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          rec_end_nxt = in_data.record_end;
          state_nxt   = S_DECODE;
        end
      end

      S_DECODE: begin
        if (dec_done) begin
          state_nxt = S_UPDATE;
        end
      end

      S_UPDATE: begin
        if (!started_r) begin
          // First sample of a recording opens a run at index 0.
          prev_code_nxt    = dec_code;
          run_start_nxt    = '0;
          sample_count_nxt = INDEX_BITS'(1);
          started_nxt      = 1'b1;
        end else if (dec_code != prev_code_r) begin
          // Code change: close the open run at the current index.
          changed          = 1'b1;
          cl_code_nxt      = prev_code_r;
          cl_start_nxt     = run_start_r;
          cl_end_nxt       = sample_count_r;
          cl_final_nxt     = 1'b0;
          prev_code_nxt    = dec_code;
          run_start_nxt    = sample_count_r;
          sample_count_nxt = count_inc;
        end else begin
          sample_count_nxt = count_inc;
        end

        if (changed) begin
          end_pend_nxt = rec_end_r;
          state_nxt    = S_CHECK;
        end else if (rec_end_r) begin
          // Close the final run straight away.
          cl_code_nxt  = dec_code;
          cl_start_nxt = run_start_nxt;
          cl_end_nxt   = sample_count_nxt;
          cl_final_nxt = 1'b1;
          end_pend_nxt = 1'b0;
          state_nxt    = S_CHECK;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_CHECK: begin
        if (cl_start_r == '0 || (cfg_r.drop_zero_codes && cl_code_r == '0) ||
            cl_end_r <= cl_start_r) begin
          state_nxt = S_NEXT;
        end else if (cfg_r.min_interval_samples == '0 || recent_fill_r == '0) begin
          state_nxt = S_EMIT;
        end else begin
          scan_idx_nxt = '0;
          state_nxt    = S_SCAN;
        end
      end

      S_SCAN: begin
        if (scan_hit) begin
          state_nxt = S_NEXT;
        end else if (FILL_W'(scan_idx_r) + 1'b1 == recent_fill_r) begin
          state_nxt = S_EMIT;
        end else begin
          scan_idx_nxt = IDX_W'(scan_idx_r + 1'b1);
        end
      end

      S_EMIT: begin
        // Hold until the output register is free or frees this cycle.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt                 = 1'b1;
          out_data_nxt.event_code       = cl_code_r;
          out_data_nxt.onset_index      = FIELD_W'(cl_start_r);
          out_data_nxt.duration_samples = FIELD_W'(cl_end_r - cl_start_r);
          out_data_nxt.final_event      = cl_final_r;
          if (cfg_r.min_interval_samples != '0) begin
            ram_we = 1'b1;
            if (recent_fill_r < FILL_W'(RECENT_DEPTH)) begin
              recent_fill_nxt = recent_fill_r + 1'b1;
            end else if (replace_slot_r == IDX_W'(RECENT_DEPTH - 1)) begin
              replace_slot_nxt = '0;
            end else begin
              replace_slot_nxt = replace_slot_r + 1'b1;
            end
          end
          state_nxt = S_NEXT;
        end
      end

      S_NEXT: begin
        if (cl_final_r) begin
          // End of recording: return the tracker to its reset state.
          prev_code_nxt    = '0;
          run_start_nxt    = '0;
          sample_count_nxt = '0;
          started_nxt      = 1'b0;
          recent_fill_nxt  = '0;
          replace_slot_nxt = '0;
          state_nxt        = S_IDLE;
        end else if (end_pend_r) begin
          // Second close of the sample: the one-sample final run.
          cl_code_nxt  = prev_code_r;
          cl_start_nxt = run_start_r;
          cl_end_nxt   = sample_count_r;
          cl_final_nxt = 1'b1;
          end_pend_nxt = 1'b0;
          state_nxt    = S_CHECK;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      prev_code_r    <= '0;
      run_start_r    <= '0;
      sample_count_r <= '0;
      started_r      <= 1'b0;
      recent_fill_r  <= '0;
      replace_slot_r <= '0;
      end_pend_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      prev_code_r    <= prev_code_nxt;
      run_start_r    <= run_start_nxt;
      sample_count_r <= sample_count_nxt;
      started_r      <= started_nxt;
      recent_fill_r  <= recent_fill_nxt;
      replace_slot_r <= replace_slot_nxt;
      end_pend_r     <= end_pend_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    rec_end_r  <= rec_end_nxt;
    cl_code_r  <= cl_code_nxt;
    cl_start_r <= cl_start_nxt;
    cl_end_r   <= cl_end_nxt;
    cl_final_r <= cl_final_nxt;
    scan_idx_r <= scan_idx_nxt;
    out_data_r <= out_data_nxt;
  end

  // Register file.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.code_mask            <= '0;
      cfg_r.zero_threshold       <= '0;
      cfg_r.drop_zero_codes      <= 1'b1;
      cfg_r.min_interval_samples <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_CODE_MASK:    cfg_r.code_mask            <= cfg_wdata[CODE_W-1:0];
        REG_ZERO_THR:     cfg_r.zero_threshold       <= cfg_wdata[THR_W-1:0];
        REG_DROP_ZERO:    cfg_r.drop_zero_codes      <= cfg_wdata[0];
        REG_MIN_INTERVAL: cfg_r.min_interval_samples <= cfg_wdata[FIELD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // An idle tracker has counted no samples.
  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    !started_r |-> sample_count_r == '0)
    else $error("sample count nonzero while no run is open");

  // The fill count never passes the table depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    recent_fill_r <= FILL_W'(RECENT_DEPTH))
    else $error("debounce table fill count out of range");

  // A scan only runs with debounce on and entries to visit.
  a_scan_cond: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> cfg_r.min_interval_samples != '0 && recent_fill_r != '0)
    else $error("table scan without entries or with debounce off");

  // A newly loaded event never carries a zero length.
  a_nonzero_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT && (!out_valid_r || !out_stall) |=>
      out_valid_r && out_data_r.duration_samples != '0)
    else $error("event loaded with zero duration");

endmodule
